/* rtl/core/phong_point_light_shader_macros.svh */
// assertion macros for the phong point light shader
// no dependencies; included by the files that carry concurrent checks
`ifndef PHONG_POINT_LIGHT_SHADER_MACROS_SVH
`define PHONG_POINT_LIGHT_SHADER_MACROS_SVH

// same-cycle implication, disabled during reset
`define PPLSH_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("pplsh check failed");

// next-cycle implication, disabled during reset
`define PPLSH_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("pplsh check failed");

`endif

/* rtl/core/pplsh_pkg.sv */
// shared types, widths, latencies and tables for the phong point light shader
// no dependencies; imported by every module of the block
package pplsh_pkg;

  localparam int NORM_IN_W = 50;
  localparam int MAG_W     = 50;
  localparam int POS_W     = 6;
  localparam int FRM_W     = 20;
  localparam int SQRT_STEPS = 21;
  localparam int SUMSQ_W   = 43;
  localparam int LEN_W     = 21;
  localparam int DIV_STEPS = 15;
  localparam int REM_W     = 36;
  localparam int NORM_LAT  = 5 + SQRT_STEPS + 1 + DIV_STEPS + 1;

  localparam int POW_SQ    = 16;
  localparam int POW_MUL   = 10;
  localparam int POW_LAT   = 1 + POW_SQ + 3 + POW_MUL + 1;

  localparam int POW_OUT_IDX = 2 * NORM_LAT + 4 + POW_LAT;
  localparam int PIPE_LAT    = POW_OUT_IDX + 3;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_LIGHT_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LIGHT_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LIGHT_Z   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_AMBIENT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DIFFUSE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SPECULAR  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SHININESS = 3'd6;

  typedef logic signed [NORM_IN_W-1:0] nvec_t;
  typedef logic signed [15:0] unit_t;

  // leading one position of a magnitude word
  function automatic logic [POS_W-1:0] lead_pos(input logic [MAG_W-1:0] v);
    logic [POS_W-1:0] p;
    p = '0;
    for (int i = 0; i < MAG_W; i++) begin
      if (v[i]) p = POS_W'(i);
    end
    return p;
  endfunction

  // 2^(2^-(k+1)) in Q.16
  function automatic logic [16:0] exp2_factor(input logic [3:0] k);
    logic [16:0] c;
    case (k)
      4'd0: c = 17'd92682;
      4'd1: c = 17'd77936;
      4'd2: c = 17'd71468;
      4'd3: c = 17'd68438;
      4'd4: c = 17'd66971;
      4'd5: c = 17'd66250;
      4'd6: c = 17'd65892;
      4'd7: c = 17'd65714;
      4'd8: c = 17'd65625;
      4'd9: c = 17'd65580;
      default: c = 17'd65536;
    endcase
    return c;
  endfunction

endpackage

/* rtl/core/phong_point_light_shader.sv */
// phong point light shader top: config registers, dot products, color sums
// depends on pplsh_pkg, pplsh_norm, pplsh_power and the assertion macros
//
// usage: one ray hit word per cycle on the input channel (in_valid/in_ready),
// one shaded rgb word per hit on the output channel (out_valid/out_ready).
// configuration words go on the cfg channel (cfg_index, cfg_data), which is
// always ready; write it only while no hit is in flight.
// the pipeline has 124 register stages. the light and view normalizers run
// side by side (43 stages each: 21-stage root, 15-stage divider), then the
// reflection normalizer (43 stages), a 31-stage power pipeline, and seven
// stages of input capture, dot products, rounding and sums.
// throughput is one hit per cycle; the whole pipeline advances together.
// when the receiver stalls with a word waiting, every stage holds and
// in_ready drops in the same cycle; nothing is lost or repeated.
// reset clears all valid bits and puts the registers at their reset values
// (light at origin, zero color terms, shininess 1.0).
`include "phong_point_light_shader_macros.svh"
module phong_point_light_shader import pplsh_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [31:0]   hit_x,
  input  logic signed [31:0]   hit_y,
  input  logic signed [31:0]   hit_z,
  input  logic signed [15:0]   dir_x,
  input  logic signed [15:0]   dir_y,
  input  logic signed [15:0]   dir_z,
  input  logic signed [15:0]   norm_x,
  input  logic signed [15:0]   norm_y,
  input  logic signed [15:0]   norm_z,
  input  logic                 shadowed,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [15:0]          out_red,
  output logic [15:0]          out_green,
  output logic [15:0]          out_blue,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [47:0]          cfg_data
);

  logic signed [31:0] light_x, light_y, light_z;
  logic [47:0] ambient_rgb, diffuse_rgb, specular_rgb;
  logic [15:0] shininess;

  logic en;
  logic [PIPE_LAT-1:0] vld;

  logic signed [32:0] t0_d [3];
  logic signed [16:0] t0_vd [3];
  unit_t              t0_n [3];
  logic               t0_sh;

  nvec_t l_in [3], v_in [3], r_in [3];
  unit_t l_u [3], v_u [3], r_u [3];

  unit_t dl_n  [NORM_LAT][3];
  logic  dl_sh [NORM_LAT];

  logic signed [31:0] t1_p [3];
  unit_t t1_l [3], t1_n [3], t1_v [3];
  logic  t1_sh;
  logic signed [33:0] t2_dnl;
  unit_t t2_l [3], t2_n [3], t2_v [3];
  logic  t2_sh;

  unit_t       dr_v  [NORM_LAT][3];
  logic [15:0] dr_fd [NORM_LAT];
  logic        dr_sh [NORM_LAT];

  logic signed [31:0] t4_p [3];
  logic [15:0] t4_fd;
  logic        t4_sh;
  logic [14:0] t5_x;
  logic [15:0] t5_fd;
  logic        t5_sh;

  logic [15:0] pw_fs;
  logic [15:0] dp_fd [POW_LAT];
  logic        dp_sh [POW_LAT];

  logic [15:0] t6_a  [3];
  logic [17:0] t6_td [3];
  logic [17:0] t6_ts [3];
  logic        t6_sh;
  logic        t7_sh;

  logic signed [50:0] r_prod [3];
  logic signed [50:0] r_lsh  [3];
  logic signed [33:0] dnl_rnd, drv_sum, drv_rnd;
  logic [15:0] fd_c;
  logic [14:0] x_c;
  logic [18:0] ch_sum [3];
  logic [15:0] ch_out [3];

  assign en        = !out_valid || out_ready;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;
  assign out_valid = vld[PIPE_LAT-1];

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      light_x      <= '0;
      light_y      <= '0;
      light_z      <= '0;
      ambient_rgb  <= '0;
      diffuse_rgb  <= '0;
      specular_rgb <= '0;
      shininess    <= 16'd256;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_LIGHT_X:   light_x      <= $signed(cfg_data[31:0]);
        REG_LIGHT_Y:   light_y      <= $signed(cfg_data[31:0]);
        REG_LIGHT_Z:   light_z      <= $signed(cfg_data[31:0]);
        REG_AMBIENT:   ambient_rgb  <= cfg_data;
        REG_DIFFUSE:   diffuse_rgb  <= cfg_data;
        REG_SPECULAR:  specular_rgb <= cfg_data;
        REG_SHININESS: shininess    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[PIPE_LAT-2:0], in_valid};
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      l_in[k] = NORM_IN_W'(t0_d[k]);
      v_in[k] = NORM_IN_W'(t0_vd[k]);
    end
  end

  pplsh_norm u_norm_l (.clk(clk), .en(en), .vin(l_in), .uout(l_u));
  pplsh_norm u_norm_v (.clk(clk), .en(en), .vin(v_in), .uout(v_u));

  // reflection vector and diffuse factor
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      r_prod[k] = 51'(t2_dnl) * 51'(t2_n[k]);
      r_lsh[k]  = 51'(t2_l[k]) <<< 28;
      r_in[k]   = NORM_IN_W'((r_prod[k] <<< 1) - r_lsh[k]);
    end
    dnl_rnd = t2_dnl + 34'sd8192;
    if (t2_dnl > 34'sd0) begin
      fd_c = (dnl_rnd[33:14] > 20'd65535) ? 16'hFFFF : dnl_rnd[29:14];
    end else begin
      fd_c = '0;
    end
  end

  pplsh_norm u_norm_r (.clk(clk), .en(en), .vin(r_in), .uout(r_u));

  always_comb begin
    drv_sum = 34'(t4_p[0]) + 34'(t4_p[1]) + 34'(t4_p[2]);
    drv_rnd = drv_sum + 34'sd8192;
    if (drv_sum > 34'sd0) begin
      x_c = (drv_rnd[33:14] > 20'd16384) ? 15'd16384 : drv_rnd[28:14];
    end else begin
      x_c = '0;
    end
  end

  pplsh_power u_power (.clk(clk), .en(en), .x(t5_x), .e(shininess), .fs(pw_fs));

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      ch_sum[c] = t6_sh ? 19'(t6_a[c])
                        : 19'(t6_a[c]) + 19'(t6_td[c]) + 19'(t6_ts[c]);
      ch_out[c] = (ch_sum[c] > 19'd65535) ? 16'hFFFF : ch_sum[c][15:0];
    end
  end

  always_ff @(posedge clk) begin
    logic [31:0] pd, ps;
    if (en) begin
      t0_d[0]  <= 33'(light_x) - 33'(hit_x);
      t0_d[1]  <= 33'(light_y) - 33'(hit_y);
      t0_d[2]  <= 33'(light_z) - 33'(hit_z);
      t0_vd[0] <= -17'(dir_x);
      t0_vd[1] <= -17'(dir_y);
      t0_vd[2] <= -17'(dir_z);
      t0_n[0]  <= norm_x;
      t0_n[1]  <= norm_y;
      t0_n[2]  <= norm_z;
      t0_sh    <= shadowed;

      dl_n[0]  <= t0_n;
      dl_sh[0] <= t0_sh;
      for (int i = 1; i < NORM_LAT; i++) begin
        dl_n[i]  <= dl_n[i-1];
        dl_sh[i] <= dl_sh[i-1];
      end

      for (int k = 0; k < 3; k++) begin
        t1_p[k] <= 32'(l_u[k]) * 32'(dl_n[NORM_LAT-1][k]);
      end
      t1_l  <= l_u;
      t1_v  <= v_u;
      t1_n  <= dl_n[NORM_LAT-1];
      t1_sh <= dl_sh[NORM_LAT-1];

      t2_dnl <= 34'(t1_p[0]) + 34'(t1_p[1]) + 34'(t1_p[2]);
      t2_l   <= t1_l;
      t2_n   <= t1_n;
      t2_v   <= t1_v;
      t2_sh  <= t1_sh;

      // side data runs beside the reflection normalizer
      dr_v[0]  <= t2_v;
      dr_fd[0] <= fd_c;
      dr_sh[0] <= t2_sh;
      for (int i = 1; i < NORM_LAT; i++) begin
        dr_v[i]  <= dr_v[i-1];
        dr_fd[i] <= dr_fd[i-1];
        dr_sh[i] <= dr_sh[i-1];
      end

      for (int k = 0; k < 3; k++) begin
        t4_p[k] <= 32'(r_u[k]) * 32'(dr_v[NORM_LAT-1][k]);
      end
      t4_fd <= dr_fd[NORM_LAT-1];
      t4_sh <= dr_sh[NORM_LAT-1];

      t5_x  <= x_c;
      t5_fd <= t4_fd;
      t5_sh <= t4_sh;

      dp_fd[0] <= t5_fd;
      dp_sh[0] <= t5_sh;
      for (int i = 1; i < POW_LAT; i++) begin
        dp_fd[i] <= dp_fd[i-1];
        dp_sh[i] <= dp_sh[i-1];
      end

      // per channel: coefficient times factor, rounded back to UQ4.12
      for (int c = 0; c < 3; c++) begin
        pd = 32'(diffuse_rgb[16*c +: 16]) * 32'(dp_fd[POW_LAT-1]) + 32'd8192;
        ps = 32'(specular_rgb[16*c +: 16]) * 32'(pw_fs) + 32'd8192;
        t6_a[c]  <= ambient_rgb[16*c +: 16];
        t6_td[c] <= pd[31:14];
        t6_ts[c] <= ps[31:14];
      end
      t6_sh <= dp_sh[POW_LAT-1];

      out_red   <= ch_out[0];
      out_green <= ch_out[1];
      out_blue  <= ch_out[2];
      t7_sh     <= t6_sh;
    end
  end

  // a stall freezes the whole valid chain
  `PPLSH_ASSERT_NXT(a_stall_holds, clk, rst, !en, $stable(vld))
  // the power stage never exceeds one in Q1.14
  `PPLSH_ASSERT_IMP(a_power_bound, clk, rst, vld[POW_OUT_IDX], pw_fs <= 16'd16384)
  // shadowed hits carry the ambient term alone
  `PPLSH_ASSERT_IMP(a_shadow_ambient, clk, rst, out_valid && t7_sh,
                    out_red == ambient_rgb[15:0] && out_blue == ambient_rgb[47:32])

endmodule

/* rtl/core/pplsh_norm.sv */
// pipelined vector normalizer: range shift, square sum, bitwise root, divider
// depends on pplsh_pkg
module pplsh_norm import pplsh_pkg::*; (
  input  logic  clk,
  input  logic  en,
  input  nvec_t vin [3],
  output unit_t uout [3]
);

  logic [MAG_W-1:0] s0_mag [3];
  logic [2:0]       s0_neg;
  logic [MAG_W-1:0] s1_mag [3];
  logic [2:0]       s1_neg;
  logic [POS_W-1:0] s1_pos;
  logic             s1_zero;
  logic [FRM_W-1:0] s2_mag [3];
  logic [2:0]       s2_neg;
  logic             s2_zero;
  logic [2*FRM_W-1:0] s3_sq [3];
  logic [FRM_W-1:0] s3_mag [3];
  logic [2:0]       s3_neg;
  logic             s3_zero;

  // root stages, index 0 holds the square sum
  logic [SUMSQ_W-1:0] q_rem  [SQRT_STEPS+1];
  logic [SUMSQ_W-1:0] q_res  [SQRT_STEPS+1];
  logic [FRM_W-1:0]   q_mag  [SQRT_STEPS+1][3];
  logic [2:0]         q_neg  [SQRT_STEPS+1];
  logic               q_zero [SQRT_STEPS+1];
  logic [SUMSQ_W-1:0] q_rem_next [SQRT_STEPS+1];
  logic [SUMSQ_W-1:0] q_res_next [SQRT_STEPS+1];

  // divider stages, index 0 holds the rounded numerator
  logic [REM_W-1:0] d_rem  [DIV_STEPS+1][3];
  logic [14:0]      d_quo  [DIV_STEPS+1][3];
  logic [LEN_W-1:0] d_den  [DIV_STEPS+1];
  logic [2:0]       d_neg  [DIV_STEPS+1];
  logic             d_zero [DIV_STEPS+1];
  logic [REM_W-1:0] d_rem_next [DIV_STEPS+1][3];
  logic [14:0]      d_quo_next [DIV_STEPS+1][3];

  logic [MAG_W-1:0] or_mag;
  logic [FRM_W-1:0] shifted [3];

  always_comb begin
    or_mag = s0_mag[0] | s0_mag[1] | s0_mag[2];
    for (int k = 0; k < 3; k++) begin
      if (s1_pos >= POS_W'(FRM_W)) begin
        shifted[k] = FRM_W'(s1_mag[k] >> (s1_pos - POS_W'(FRM_W - 1)));
      end else begin
        shifted[k] = FRM_W'(s1_mag[k] << (POS_W'(FRM_W - 1) - s1_pos));
      end
    end
  end

  always_comb begin
    logic [SUMSQ_W-1:0] bit_w;
    logic [SUMSQ_W-1:0] trial;
    q_rem_next[0] = '0;
    q_res_next[0] = '0;
    for (int j = 1; j <= SQRT_STEPS; j++) begin
      bit_w = SUMSQ_W'(1) << (2 * (SQRT_STEPS - j));
      trial = q_res[j-1] + bit_w;
      if (q_rem[j-1] >= trial) begin
        q_rem_next[j] = q_rem[j-1] - trial;
        q_res_next[j] = (q_res[j-1] >> 1) + bit_w;
      end else begin
        q_rem_next[j] = q_rem[j-1];
        q_res_next[j] = q_res[j-1] >> 1;
      end
    end
  end

  always_comb begin
    logic [REM_W-1:0] sub;
    for (int k = 0; k < 3; k++) begin
      d_rem_next[0][k] = '0;
      d_quo_next[0][k] = '0;
    end
    for (int i = 1; i <= DIV_STEPS; i++) begin
      for (int k = 0; k < 3; k++) begin
        sub = REM_W'(d_den[i-1]) << (DIV_STEPS - i);
        d_quo_next[i][k] = d_quo[i-1][k];
        if (d_rem[i-1][k] >= sub) begin
          d_rem_next[i][k] = d_rem[i-1][k] - sub;
          d_quo_next[i][k][DIV_STEPS - i] = 1'b1;
        end else begin
          d_rem_next[i][k] = d_rem[i-1][k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        s0_neg[k] <= vin[k][NORM_IN_W-1];
        s0_mag[k] <= vin[k][NORM_IN_W-1] ? MAG_W'(-vin[k]) : MAG_W'(vin[k]);
      end
      s1_mag  <= s0_mag;
      s1_neg  <= s0_neg;
      s1_pos  <= lead_pos(or_mag);
      s1_zero <= (or_mag == '0);
      s2_mag  <= shifted;
      s2_neg  <= s1_neg;
      s2_zero <= s1_zero;
      for (int k = 0; k < 3; k++) begin
        s3_sq[k] <= (2*FRM_W)'(s2_mag[k]) * (2*FRM_W)'(s2_mag[k]);
      end
      s3_mag  <= s2_mag;
      s3_neg  <= s2_neg;
      s3_zero <= s2_zero;

      q_rem[0]  <= SUMSQ_W'(s3_sq[0]) + SUMSQ_W'(s3_sq[1]) + SUMSQ_W'(s3_sq[2]);
      q_res[0]  <= '0;
      q_mag[0]  <= s3_mag;
      q_neg[0]  <= s3_neg;
      q_zero[0] <= s3_zero;
      for (int j = 1; j <= SQRT_STEPS; j++) begin
        q_rem[j]  <= q_rem_next[j];
        q_res[j]  <= q_res_next[j];
        q_mag[j]  <= q_mag[j-1];
        q_neg[j]  <= q_neg[j-1];
        q_zero[j] <= q_zero[j-1];
      end

      // numerator mag * 16384 + len / 2
      for (int k = 0; k < 3; k++) begin
        d_rem[0][k] <= (REM_W'(q_mag[SQRT_STEPS][k]) << 14)
                     + REM_W'(q_res[SQRT_STEPS][LEN_W-1:1]);
        d_quo[0][k] <= '0;
      end
      d_den[0]  <= q_res[SQRT_STEPS][LEN_W-1:0];
      d_neg[0]  <= q_neg[SQRT_STEPS];
      d_zero[0] <= q_zero[SQRT_STEPS];
      for (int i = 1; i <= DIV_STEPS; i++) begin
        d_rem[i]  <= d_rem_next[i];
        d_quo[i]  <= d_quo_next[i];
        d_den[i]  <= d_den[i-1];
        d_neg[i]  <= d_neg[i-1];
        d_zero[i] <= d_zero[i-1];
      end

      for (int k = 0; k < 3; k++) begin
        if (d_zero[DIV_STEPS]) begin
          uout[k] <= '0;
        end else if (d_neg[DIV_STEPS][k]) begin
          uout[k] <= -$signed({1'b0, d_quo[DIV_STEPS][k]});
        end else begin
          uout[k] <= $signed({1'b0, d_quo[DIV_STEPS][k]});
        end
      end
    end
  end

endmodule

/* rtl/core/pplsh_power.sv */
// pipelined specular power: log2 by repeated squaring, exponent multiply,
// exp2 by table factors; depends on pplsh_pkg
module pplsh_power import pplsh_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [14:0] x,
  input  logic [15:0] e,
  output logic [15:0] fs
);

  logic [15:0] sq_y    [POW_SQ+1];
  logic [15:0] sq_frac [POW_SQ+1];
  logic [3:0]  sq_pos  [POW_SQ+1];
  logic [15:0] sq_e    [POW_SQ+1];
  logic        sq_full [POW_SQ+1];
  logic        sq_zero [POW_SQ+1];
  logic [15:0] sq_y_next    [POW_SQ+1];
  logic [15:0] sq_frac_next [POW_SQ+1];

  logic [19:0] l_l2;
  logic [15:0] l_e;
  logic        l_full, l_zero;
  logic [35:0] m_t;
  logic        m_full, m_zero;

  logic [16:0] ex_p    [POW_MUL+1];
  logic [9:0]  ex_g    [POW_MUL+1];
  logic [4:0]  ex_s    [POW_MUL+1];
  logic        ex_full [POW_MUL+1];
  logic        ex_zero [POW_MUL+1];
  logic [16:0] ex_p_next [POW_MUL+1];

  logic [3:0]  pos;
  logic [11:0] t_int;
  logic [23:0] t_frac;
  logic        f_zero;
  logic        big;
  logic [24:0] g_diff;
  logic [17:0] rnd;

  always_comb begin
    pos = '0;
    for (int k = 0; k < 14; k++) begin
      if (x[k]) pos = 4'(k);
    end
  end

  always_comb begin
    logic [31:0] prod;
    logic [16:0] yt;
    sq_y_next[0] = '0;
    sq_frac_next[0] = '0;
    for (int j = 1; j <= POW_SQ; j++) begin
      prod = 32'(sq_y[j-1]) * 32'(sq_y[j-1]);
      yt = prod[31:15];
      sq_y_next[j] = yt[16] ? yt[16:1] : yt[15:0];
      sq_frac_next[j] = {sq_frac[j-1][14:0], yt[16]};
    end
  end

  always_comb begin
    t_int  = m_t[35:24];
    t_frac = m_t[23:0];
    f_zero = (t_frac == '0);
    big    = f_zero ? (t_int >= 12'd16) : (t_int >= 12'd15);
    g_diff = 25'h1000000 - 25'(t_frac);
  end

  always_comb begin
    logic [33:0] prod;
    ex_p_next[0] = '0;
    for (int k = 1; k <= POW_MUL; k++) begin
      prod = 34'(ex_p[k-1]) * 34'(exp2_factor(4'(k - 1))) + 34'd32768;
      ex_p_next[k] = ex_g[k-1][POW_MUL - k] ? prod[32:16] : ex_p[k-1];
    end
  end

  always_comb begin
    rnd = (18'(ex_p[POW_MUL]) + (18'd1 << (ex_s[POW_MUL] - 5'd1))) >> ex_s[POW_MUL];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_full[0] <= x[14] || (e == '0);
      sq_zero[0] <= (x == '0);
      sq_pos[0]  <= pos;
      sq_y[0]    <= {2'b00, x[13:0]} << (4'd15 - pos);
      sq_frac[0] <= '0;
      sq_e[0]    <= e;
      for (int j = 1; j <= POW_SQ; j++) begin
        sq_y[j]    <= sq_y_next[j];
        sq_frac[j] <= sq_frac_next[j];
        sq_pos[j]  <= sq_pos[j-1];
        sq_e[j]    <= sq_e[j-1];
        sq_full[j] <= sq_full[j-1];
        sq_zero[j] <= sq_zero[j-1];
      end

      l_l2   <= {4'd14 - sq_pos[POW_SQ], 16'd0} - 20'(sq_frac[POW_SQ]);
      l_e    <= sq_e[POW_SQ];
      l_full <= sq_full[POW_SQ];
      l_zero <= sq_zero[POW_SQ];

      m_t    <= 36'(l_e) * 36'(l_l2);
      m_full <= l_full;
      m_zero <= l_zero;

      ex_p[0]    <= 17'd65536;
      ex_g[0]    <= f_zero ? 10'd0 : g_diff[23:14];
      ex_s[0]    <= f_zero ? (5'(t_int[3:0]) + 5'd2) : (5'(t_int[3:0]) + 5'd3);
      ex_full[0] <= m_full;
      ex_zero[0] <= m_zero || big;
      for (int k = 1; k <= POW_MUL; k++) begin
        ex_p[k]    <= ex_p_next[k];
        ex_g[k]    <= ex_g[k-1];
        ex_s[k]    <= ex_s[k-1];
        ex_full[k] <= ex_full[k-1];
        ex_zero[k] <= ex_zero[k-1];
      end

      if (ex_full[POW_MUL]) begin
        fs <= 16'd16384;
      end else if (ex_zero[POW_MUL]) begin
        fs <= '0;
      end else begin
        fs <= rnd[15:0];
      end
    end
  end

endmodule
